// ===== hdl/scba_pkg.sv =====
package scba_pkg;

    localparam int DEFAULT_NUM_BLOCKS = 16;

    // size classes 32 .. 4096 bytes, class index c = log2(size) - 5
    localparam int MIN_CLASS     = 5;
    localparam int NUM_CLASSES   = 8;
    localparam int CLASS_W       = 3;
    localparam int MAX_CHUNKS    = 128;     // chunks per block in the smallest class
    localparam int MAX_REQUEST   = 4096;
    localparam int BLOCK_SHIFT   = 15;      // 32 KiB block stride
    localparam int CLASS_SHIFT   = 12;      // 4 KiB class region stride

    localparam int REQ_W   = 16;
    localparam int ADDR_W  = 32;
    localparam int BYTES_W = 13;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 48;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } state_t;

    typedef struct packed {
        logic load_req;
        logic commit;
    } cmd_t;

endpackage

// ===== hdl/scba_ctrl.sv =====
module scba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output scba_pkg::cmd_t  cmd
);

    scba_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == scba_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.load_req  = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            scba_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = scba_pkg::ST_EVAL;
                end
            end
            scba_pkg::ST_EVAL:
            begin
                // result goes out once the output register is free
                if (out_free)
                begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = scba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= scba_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == scba_pkg::ST_EVAL))
        else $error("accepted word did not start evaluation");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid_reg)
        else $error("committed result not presented");

endmodule

// ===== hdl/scba_dp.sv =====
module scba_dp #(
    parameter int NUM_BLOCKS = scba_pkg::DEFAULT_NUM_BLOCKS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  scba_pkg::cmd_t               cmd,
    input  logic [scba_pkg::REQ_W-1:0]   request_bytes,
    input  logic                         cfg_we,
    input  logic [scba_pkg::ADDR_W-1:0]  cfg_wdata,
    output logic                         granted,
    output logic [scba_pkg::ADDR_W-1:0]  chunk_address,
    output logic [scba_pkg::BYTES_W-1:0] chunk_bytes
);

    // allocation is strictly first fit with no free, so the map of each class
    // is a prefix of set bits; one fill count per class stands in for it
    localparam int LIMIT_MAX = NUM_BLOCKS * scba_pkg::MAX_CHUNKS;
    localparam int CNT_W     = $clog2(LIMIT_MAX + 1);

    logic [scba_pkg::REQ_W-1:0]   req_reg;
    logic [scba_pkg::ADDR_W-1:0]  base_reg;
    logic [CNT_W-1:0]             cnt_reg [scba_pkg::NUM_CLASSES];
    logic                         granted_reg;
    logic [scba_pkg::ADDR_W-1:0]  addr_reg;
    logic [scba_pkg::BYTES_W-1:0] bytes_reg;

    logic [11:0]                  req_m1;
    logic [scba_pkg::CLASS_W-1:0] cls;
    logic                         size_ok;
    logic [CNT_W-1:0]             fill;
    logic [CNT_W-1:0]             limit;
    logic [CNT_W-1:0]             mask;
    logic                         grant;
    logic [scba_pkg::ADDR_W-1:0]  blk_off;
    logic [scba_pkg::ADDR_W-1:0]  slot_off;
    logic [scba_pkg::ADDR_W-1:0]  cls_off;
    logic [scba_pkg::ADDR_W-1:0]  addr_next;
    logic [scba_pkg::BYTES_W-1:0] bytes_next;

    assign size_ok = (req_reg != '0) &&
                     (req_reg <= scba_pkg::REQ_W'(scba_pkg::MAX_REQUEST));
    assign req_m1  = 12'(req_reg - 16'd1);

    // smallest class that holds the request
    always_comb
    begin
        cls = '0;
        for (int j = scba_pkg::MIN_CLASS; j < 12; j++)
        begin
            if (req_m1[j])
            begin
                cls = scba_pkg::CLASS_W'(j - (scba_pkg::MIN_CLASS - 1));
            end
        end
    end

    assign fill  = cnt_reg[cls];
    assign limit = CNT_W'(LIMIT_MAX) >> cls;
    assign mask  = CNT_W'((scba_pkg::MAX_CHUNKS >> cls) - 1);
    assign grant = size_ok && (fill < limit);

    assign blk_off  = scba_pkg::ADDR_W'(fill >> (3'd7 - cls)) << scba_pkg::BLOCK_SHIFT;
    assign slot_off = scba_pkg::ADDR_W'(fill & mask) << (4'(cls) + 4'd5);
    assign cls_off  = scba_pkg::ADDR_W'(cls) << scba_pkg::CLASS_SHIFT;

    assign addr_next  = grant ? (base_reg + blk_off + cls_off + slot_off) : '0;
    assign bytes_next = grant ? (scba_pkg::BYTES_W'(1) << (4'(cls) + 4'd5)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            req_reg  <= '0;
            for (int i = 0; i < scba_pkg::NUM_CLASSES; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (cmd.load_req)
            begin
                req_reg <= request_bytes;
            end
            if (cmd.commit && grant)
            begin
                cnt_reg[cls] <= fill + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            granted_reg <= grant;
            addr_reg    <= addr_next;
            bytes_reg   <= bytes_next;
        end
    end

    assign granted       = granted_reg;
    assign chunk_address = addr_reg;
    assign chunk_bytes   = bytes_reg;

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !grant) |=> (addr_reg == '0 && bytes_reg == '0 && !granted_reg))
        else $error("refused word carries nonzero payload");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= limit)
        else $error("class fill count past heap capacity");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && grant) |=> (cnt_reg[$past(cls)] == $past(fill) + CNT_W'(1)))
        else $error("grant did not advance its class count");

endmodule

// ===== hdl/size_class_bitmap_allocator.sv =====
// a word accepted in idle moves to the evaluate step, whose result shows on m_tvalid once the output register is free
// the next word is taken while the result waits; no word is taken during the evaluate step
// a stalled output holds the evaluate step, the fill count lookup is combinational
// reset (rst_n, async, active low): every chunk free, heap_base 0, no word pending
module size_class_bitmap_allocator #(
    parameter int NUM_BLOCKS = scba_pkg::DEFAULT_NUM_BLOCKS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [scba_pkg::TDATA_IN_W-1:0]  s_tdata,   // request_bytes
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [scba_pkg::TDATA_OUT_W-1:0] m_tdata,   // granted, chunk_address, chunk_bytes
    input  logic                             cfg_we,
    input  logic [scba_pkg::ADDR_W-1:0]      cfg_wdata
);

    scba_pkg::cmd_t               cmd;
    logic                         granted;
    logic [scba_pkg::ADDR_W-1:0]  chunk_address;
    logic [scba_pkg::BYTES_W-1:0] chunk_bytes;

    scba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    scba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .request_bytes (s_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .granted       (granted),
        .chunk_address (chunk_address),
        .chunk_bytes   (chunk_bytes)
    );

    assign m_tdata = {2'b00, chunk_bytes, chunk_address, granted};

endmodule
